// ----- rtl/hfd_pkg.sv -----
// Shared types and constants of the heartbeat failure detector.
`timescale 1ns / 1ps

package hfd_pkg;

    localparam int unsigned MASK_BITS  = 32;
    localparam int unsigned COUNT_BITS = 16;
    localparam int unsigned CFG_TIME_W = 16;
    localparam int unsigned SELF_W     = 5;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_MSG  = 2'd1,
        MODE_READ = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        REG_TIMEOUT = 2'd0,
        REG_SELF    = 2'd1,
        REG_END     = 2'd2
    } t_reg_idx;

    localparam logic [CFG_TIME_W-1:0] TIMEOUT_RST  = 16'd10;
    localparam logic [SELF_W-1:0]     SELF_RST     = 5'd0;
    localparam logic [CFG_TIME_W-1:0] END_TIME_RST = 16'hFFFF;

    typedef struct packed {
        logic [CFG_TIME_W-1:0] silence_timeout;
        logic [SELF_W-1:0]     self_index;
        logic [CFG_TIME_W-1:0] end_time;
    } t_cfg;

    typedef struct packed {
        logic                  upd;
        logic                  any_seen;
        logic [CFG_TIME_W-1:0] timeout;
    } t_lane_ctrl;

endpackage

// ----- rtl/hfd_if.sv -----
// Request and result channel interfaces of the heartbeat failure detector.
`timescale 1ns / 1ps

interface hfd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] seen_mask;
    logic [4:0]  node_index;

    modport source (output valid, mode, seen_mask, node_index, input ready);
    modport sink (input valid, mode, seen_mask, node_index, output ready);
endinterface

interface hfd_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] dead_mask;
    logic [15:0] heartbeat_count;
    logic [15:0] time_now;
    logic        finished;

    modport source (output valid, dead_mask, heartbeat_count, time_now, finished,
                    input ready);
    modport sink (input valid, dead_mask, heartbeat_count, time_now, finished,
                  output ready);
endinterface

// ----- rtl/hfd_cfg_regs.sv -----
// APB configuration registers of the heartbeat failure detector.
`timescale 1ns / 1ps

module hfd_cfg_regs import hfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.silence_timeout <= TIMEOUT_RST;
            r_cfg.self_index      <= SELF_RST;
            r_cfg.end_time        <= END_TIME_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TIMEOUT: r_cfg.silence_timeout <= pwdata[CFG_TIME_W-1:0];
                REG_SELF:    r_cfg.self_index      <= pwdata[SELF_W-1:0];
                REG_END:     r_cfg.end_time        <= pwdata[CFG_TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TIMEOUT: prdata = APB_DATA_W'(r_cfg.silence_timeout);
            REG_SELF:    prdata = APB_DATA_W'(r_cfg.self_index);
            REG_END:     prdata = APB_DATA_W'(r_cfg.end_time);
            default:     prdata = '0;
        endcase
    end

endmodule

// ----- rtl/hfd_lane.sv -----
// One membership entry: last-heard time, heartbeat count and dead mark.
`timescale 1ns / 1ps

module hfd_lane import hfd_pkg::*; #(
    parameter int unsigned TIME_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_lane_ctrl            i_ctrl,
    input  logic [TIME_BITS-1:0]  i_now,
    input  logic                  i_seen,
    input  logic                  i_is_self,
    output logic [COUNT_BITS-1:0] o_count_nxt,
    output logic                  o_dead_nxt
);

    localparam int unsigned CW = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;

    logic [TIME_BITS-1:0]  r_heard;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_dead;
    logic [TIME_BITS-1:0]  n_heard;
    logic                  w_refresh;
    logic [TIME_BITS-1:0]  w_silence;
    logic                  w_timed_out;

    assign w_refresh   = i_ctrl.upd && (i_seen || (i_is_self && i_ctrl.any_seen));
    assign n_heard     = w_refresh ? i_now : r_heard;
    assign w_silence   = i_now - n_heard;
    assign w_timed_out = CW'(w_silence) >= CW'(i_ctrl.timeout);

    assign o_count_nxt = (i_ctrl.upd && i_seen && (r_count != '1)) ?
                         r_count + 1'b1 : r_count;
    assign o_dead_nxt  = r_dead || (i_ctrl.upd && !i_is_self && w_timed_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heard <= '0;
            r_count <= '0;
            r_dead  <= 1'b0;
        end else begin
            r_heard <= n_heard;
            r_count <= o_count_nxt;
            r_dead  <= o_dead_nxt;
        end
    end

endmodule

// ----- rtl/hfd_merge.sv -----
// Combines the lane results into one registered result item.
`timescale 1ns / 1ps

module hfd_merge import hfd_pkg::*; #(
    parameter int unsigned NODE_COUNT = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [COUNT_BITS-1:0] i_count_nxt [NODE_COUNT],
    input  logic [NODE_COUNT-1:0] i_dead_nxt,
    input  logic [SELF_W-1:0]     i_node_index,
    input  logic [15:0]           i_time_now,
    input  logic                  i_finished,
    output logic                  o_free,
    hfd_rsp_if.source             o_rsp
);

    localparam int unsigned IW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    logic                  r_valid;
    logic [MASK_BITS-1:0]  r_dead_mask;
    logic [COUNT_BITS-1:0] r_count;
    logic [15:0]           r_time;
    logic                  r_finished;
    logic [MASK_BITS-1:0]  w_dead_mask;
    logic [IW+SELF_W-1:0]  w_idx_ext;
    logic [IW-1:0]         w_sel;
    logic                  w_hit;
    logic [COUNT_BITS-1:0] w_count;

    for (genvar i = 0; i < MASK_BITS; i++) begin : g_mask
        if (i < NODE_COUNT) begin : g_on
            assign w_dead_mask[i] = i_dead_nxt[i];
        end else begin : g_off
            assign w_dead_mask[i] = 1'b0;
        end
    end

    assign w_idx_ext = (IW + SELF_W)'(i_node_index);
    assign w_sel     = w_idx_ext[IW-1:0];
    assign w_hit     = 32'(i_node_index) < NODE_COUNT;
    assign w_count   = w_hit ? i_count_nxt[w_sel] : '0;

    assign o_free = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dead_mask <= w_dead_mask;
            r_count     <= w_count;
            r_time      <= i_time_now;
            r_finished  <= i_finished;
        end
    end

    assign o_rsp.valid           = r_valid;
    assign o_rsp.dead_mask       = r_dead_mask;
    assign o_rsp.heartbeat_count = r_count;
    assign o_rsp.time_now        = r_time;
    assign o_rsp.finished        = r_finished;

endmodule

// ----- rtl/heartbeat_failure_detector.sv -----
// Top level of the heartbeat failure detector.
`timescale 1ns / 1ps

// Membership table of a heartbeat failure detector with one hardware lane per node.
// Every request (tick, heartbeat message or count read) produces exactly one result,
// and a request is taken every clock cycle while the result register is empty or
// its content is being taken in the same cycle. Before the end time, all lanes refresh,
// count and check silence against the timeout in the cycle that takes a message, at
// the same rate; the result is registered and appears in the cycle after the request.
// There is no clearing pass: reset clears every table entry at once.
module heartbeat_failure_detector import hfd_pkg::*; #(
    parameter int unsigned NODE_COUNT = 32,
    parameter int unsigned TIME_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    hfd_req_if.sink               i_req,
    hfd_rsp_if.source             o_rsp
);

    localparam int unsigned EW = TIME_BITS + CFG_TIME_W;

    t_cfg                  w_cfg;
    t_lane_ctrl            w_ctrl;
    logic                  w_free;
    logic                  w_acc;
    logic                  w_active;
    logic [TIME_BITS-1:0]  r_time;
    logic [TIME_BITS-1:0]  n_time;
    logic [EW-1:0]         w_time_ext;
    logic [COUNT_BITS-1:0] w_count_nxt [NODE_COUNT];
    logic [NODE_COUNT-1:0] w_dead_nxt;

    hfd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign i_req.ready = w_free;
    assign w_acc       = i_req.valid && w_free;
    assign w_active    = EW'(r_time) < EW'(w_cfg.end_time);

    assign w_ctrl.upd      = w_acc && (i_req.mode == MODE_MSG) && w_active;
    assign w_ctrl.any_seen = |i_req.seen_mask;
    assign w_ctrl.timeout  = w_cfg.silence_timeout;

    assign n_time = (w_acc && (i_req.mode == MODE_TICK) && (r_time != '1)) ?
                    r_time + 1'b1 : r_time;
    assign w_time_ext = EW'(n_time);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else begin
            r_time <= n_time;
        end
    end

    for (genvar i = 0; i < NODE_COUNT; i++) begin : g_lane
        logic w_seen;
        logic w_self;

        if (i < MASK_BITS) begin : g_seen
            assign w_seen = i_req.seen_mask[i];
        end else begin : g_unseen
            assign w_seen = 1'b0;
        end
        assign w_self = 32'(w_cfg.self_index) == 32'(i);

        hfd_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_now       (r_time),
            .i_seen      (w_seen),
            .i_is_self   (w_self),
            .o_count_nxt (w_count_nxt[i]),
            .o_dead_nxt  (w_dead_nxt[i])
        );
    end

    hfd_merge #(
        .NODE_COUNT (NODE_COUNT)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_acc),
        .i_count_nxt  (w_count_nxt),
        .i_dead_nxt   (w_dead_nxt),
        .i_node_index (i_req.node_index),
        .i_time_now   (w_time_ext[15:0]),
        .i_finished   (w_time_ext >= EW'(w_cfg.end_time)),
        .o_free       (w_free),
        .o_rsp        (o_rsp)
    );

`ifndef NO_ASSERTIONS
    a_time_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_time >= $past(r_time))
        else $error("Local time decreased.");

    a_time_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_req.mode != MODE_TICK)) |=> $stable(r_time))
        else $error("Local time changed on a request that is not a tick.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> (!o_rsp.valid || o_rsp.ready))
        else $error("Request taken while a result is stalled.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> o_rsp.valid)
        else $error("Accepted request produced no result.");
`endif

endmodule

// ----- test/tb_heartbeat_failure_detector.sv -----
// Testbench of the heartbeat failure detector: a membership predictor checks every result.
`timescale 1ns / 1ps

module tb_heartbeat_failure_detector;
    import hfd_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] seen_mask;
        logic [4:0]  node_index;
        int unsigned wait_cycles;
    } t_request;

    typedef struct packed {
        logic [31:0] dead_mask;
        logic [15:0] heartbeat_count;
        logic [15:0] time_now;
        logic        finished;
    } t_report;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    hfd_req_if req_ch ();
    hfd_rsp_if rsp_ch ();

    heartbeat_failure_detector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_request queued_requests[$];
    t_report  due_reports[$];

    logic [15:0] model_time;
    logic [15:0] heard_at[32];
    logic [15:0] beat_count[32];
    logic [31:0] dead_bits;
    logic [15:0] cfg_timeout;
    logic [4:0]  cfg_self;
    logic [15:0] cfg_end;

    bit tx_idle_en;
    bit rx_idle_en;
    int unsigned gap_left;
    int unsigned stall_left;
    int mismatches;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_report advance_membership(logic [1:0] mode, logic [31:0] seen,
                                                   logic [4:0] idx);
        t_report rep;
        case (mode)
            MODE_TICK: begin
                if (model_time != 16'hFFFF) begin
                    model_time = model_time + 16'd1;
                end
            end
            MODE_MSG: begin
                if (model_time < cfg_end) begin
                    for (int i = 0; i < 32; i++) begin
                        if (seen[i]) begin
                            heard_at[i] = model_time;
                            if (beat_count[i] != 16'hFFFF) begin
                                beat_count[i] = beat_count[i] + 16'd1;
                            end
                        end
                    end
                    if (seen != 32'd0) begin
                        heard_at[cfg_self] = model_time;
                    end
                    for (int i = 0; i < 32; i++) begin
                        if (i != cfg_self && 16'(model_time - heard_at[i]) >= cfg_timeout) begin
                            dead_bits[i] = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        rep.dead_mask       = dead_bits;
        rep.heartbeat_count = beat_count[idx];
        rep.time_now        = model_time;
        rep.finished        = (model_time >= cfg_end);
        return rep;
    endfunction

    function automatic t_request random_request();
        t_request r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            r.mode = MODE_TICK;
        end else if (pick < 75) begin
            r.mode = MODE_MSG;
        end else if (pick < 95) begin
            r.mode = MODE_READ;
        end else begin
            r.mode = MODE_SPARE;
        end
        case ($urandom_range(0, 9))
            0: r.seen_mask = 32'd0;
            1, 2: r.seen_mask = $urandom;
            3: r.seen_mask = 32'd1 << $urandom_range(0, 31);
            default: r.seen_mask = ~($urandom & $urandom & $urandom);
        endcase
        r.node_index  = 5'($urandom_range(0, 31));
        r.wait_cycles = tx_idle_en ? $urandom_range(0, 16) : 0;
        return r;
    endfunction

    task automatic queue_request(logic [1:0] mode, logic [31:0] mask, logic [4:0] idx);
        t_request r;
        r.mode        = mode;
        r.seen_mask   = mask;
        r.node_index  = idx;
        r.wait_cycles = 0;
        queued_requests.push_back(r);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (queued_requests.size() != 0 || req_ch.valid || due_reports.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (3) @(negedge i_clk);
    endtask

    task automatic run_random(int count);
        repeat (count) queued_requests.push_back(random_request());
        wait_idle();
    endtask

    task automatic apb_write(t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TIMEOUT: cfg_timeout = value[15:0];
            REG_SELF:    cfg_self    = value[4:0];
            REG_END:     cfg_end     = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_request next_req;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            gap_left     <= 0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (gap_left != 0) begin
                gap_left     <= gap_left - 1;
                req_ch.valid <= 1'b0;
            end else if (queued_requests.size() != 0) begin
                next_req          = queued_requests.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.mode       <= next_req.mode;
                req_ch.seen_mask  <= next_req.seen_mask;
                req_ch.node_index <= next_req.node_index;
                gap_left          <= next_req.wait_cycles;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        int unsigned stall;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (rsp_ch.valid && rsp_ch.ready) begin
            stall = rx_idle_en ? $urandom_range(0, 16) : 0;
            rsp_ch.ready <= (stall == 0);
            stall_left   <= stall;
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= (stall_left == 1);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (due_reports.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request pending, dead_mask %0h count %0h",
                             $time, rsp_ch.dead_mask, rsp_ch.heartbeat_count);
                end else begin
                    want = due_reports.pop_front();
                    check_field("dead_mask", want.dead_mask, rsp_ch.dead_mask);
                    check_field("heartbeat_count", 32'(want.heartbeat_count),
                                32'(rsp_ch.heartbeat_count));
                    check_field("time_now", 32'(want.time_now), 32'(rsp_ch.time_now));
                    check_field("finished", 32'(want.finished), 32'(rsp_ch.finished));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                due_reports.push_back(advance_membership(req_ch.mode, req_ch.seen_mask,
                                                         req_ch.node_index));
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("heartbeat_failure_detector: mismatch");
        $finish;
    end

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_ch.valid      = 1'b0;
        req_ch.mode       = MODE_TICK;
        req_ch.seen_mask  = 32'd0;
        req_ch.node_index = 5'd0;
        rsp_ch.ready      = 1'b0;
        mismatches        = 0;
        tx_idle_en        = 1'b0;
        rx_idle_en        = 1'b0;
        model_time        = 16'd0;
        dead_bits         = 32'd0;
        cfg_timeout       = TIMEOUT_RST;
        cfg_self          = SELF_RST;
        cfg_end           = END_TIME_RST;
        for (int i = 0; i < 32; i++) begin
            heard_at[i]   = 16'd0;
            beat_count[i] = 16'd0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_request(MODE_READ, 32'd0, 5'd0);
        queue_request(MODE_SPARE, 32'hFFFF_FFFF, 5'd31);
        queue_request(MODE_MSG, 32'd0, 5'd0);
        queue_request(MODE_MSG, 32'hFFFF_FFFF, 5'd31);
        queue_request(MODE_READ, 32'd0, 5'd31);
        queue_request(MODE_TICK, 32'd0, 5'd0);
        queue_request(MODE_MSG, 32'h0000_0020, 5'd5);
        queue_request(MODE_READ, 32'hFFFF_FFFF, 5'd0);
        wait_idle();

        apb_write(REG_TIMEOUT, 32'd65535);
        apb_write(REG_SELF, 32'd31);
        apb_write(REG_END, 32'd65535);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        run_random(200);

        apb_write(REG_TIMEOUT, $urandom_range(4, 12));
        apb_write(REG_SELF, $urandom_range(0, 31));
        rx_idle_en = 1'b0;
        run_random(200);

        apb_write(REG_END, 32'(model_time) + $urandom_range(5, 20));
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        run_random(100);

        apb_write(REG_END, 32'd0);
        run_random(20);

        apb_write(REG_END, 32'd65535);
        apb_write(REG_TIMEOUT, 32'd1);
        rx_idle_en = 1'b0;
        run_random(80);

        // With no timeout every handled message kills all nodes but self, even an empty one.
        apb_write(REG_TIMEOUT, 32'd0);
        apb_write(REG_SELF, 32'd0);
        queue_request(MODE_TICK, 32'd0, 5'd0);
        queue_request(MODE_MSG, 32'd0, 5'd0);
        queue_request(MODE_READ, 32'd0, 5'd0);
        wait_idle();
        apb_write(REG_SELF, 32'd31);
        queue_request(MODE_MSG, 32'h0000_0001, 5'd0);
        queue_request(MODE_MSG, 32'hFFFF_FFFF, 5'd31);
        queue_request(MODE_READ, 32'd0, 5'd31);
        wait_idle();

        if (mismatches == 0) begin
            $display("heartbeat_failure_detector: match");
        end else begin
            $display("heartbeat_failure_detector: mismatch");
        end
        $finish;
    end

endmodule
